// ===== hdl/hsac_pkg.sv =====
// ----------------------------------------------------------------------------
// hsac_pkg
// shared widths, register indexes and magnet class codes for the hall sensor
// average classifier
// ----------------------------------------------------------------------------
package hsac_pkg;

   localparam int CHAN_W   = 4;
   localparam int SAMPLE_W = 12;
   localparam int SUM_W    = 16;
   localparam int COUNT_W  = 4;
   localparam int CLASS_W  = 2;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   typedef logic [CHAN_W-1:0]   chan_type;
   typedef logic [SAMPLE_W-1:0] sample_type;
   typedef logic [SUM_W-1:0]    sum_type;
   typedef logic [COUNT_W-1:0]  count_type;
   typedef logic [CLASS_W-1:0]  class_type;

   // magnet classes
   localparam class_type CLASS_NONE        = 2'd0;
   localparam class_type CLASS_APPROACHING = 2'd1;
   localparam class_type CLASS_DIRECT      = 2'd2;
   localparam class_type CLASS_LEAVING     = 2'd3;

   // register indexes (byte address / 4)
   localparam logic [1:0] REG_DIRECT  = 2'd0;
   localparam logic [1:0] REG_PRESENT = 2'd1;
   localparam logic [1:0] REG_ABSENT  = 2'd2;

   localparam sample_type DIRECT_RESET  = 12'd3500;
   localparam sample_type PRESENT_RESET = 12'd100;
   localparam sample_type ABSENT_RESET  = 12'd550;

endpackage

// ===== hdl/hall_sensor_average_classifier_core.sv =====
// ----------------------------------------------------------------------------
// hall_sensor_average_classifier_core
// pipeline: 3 internal stages (accumulate, divide, classify) then the result
//   register; throughput: one item per cycle while rsp_ready does not stall the
//   output, set by the per-channel sum/count update done in the first stage
// reset: synchronous, clears stage valids, per-channel sums, counts and
//   classes, and loads the threshold reset values
// ----------------------------------------------------------------------------
module hall_sensor_average_classifier_core #(
   parameter int READINGS = 10,
   parameter int CHANNELS = 4
) (
   input  logic                                  clock,
   input  logic                                  reset,

   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  hsac_pkg::chan_type                    req_channel,
   input  hsac_pkg::sample_type                  req_sample,

   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output hsac_pkg::chan_type                    rsp_out_channel,
   output hsac_pkg::sample_type                  rsp_average,
   output hsac_pkg::class_type                   rsp_magnet_class,
   output hsac_pkg::class_type                   rsp_prior_class,

   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [hsac_pkg::CSR_ADDR_W-1:0]       csr_paddr,
   input  logic [hsac_pkg::CSR_DATA_W-1:0]       csr_pwdata,
   output logic [hsac_pkg::CSR_DATA_W-1:0]       csr_prdata,
   output logic                                  csr_pready
);
   import hsac_pkg::*;

   localparam int IDX_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int CNT_CMP_W  = COUNT_W + 1;
   localparam int RECIP_SH   = 24;
   localparam int RECIP_W    = RECIP_SH + 1;
   localparam int PROD_W     = SUM_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((2 ** RECIP_SH) / READINGS + 1);
   localparam logic [CNT_CMP_W-1:0] READINGS_C = CNT_CMP_W'(READINGS);
   localparam logic [CHAN_W:0] CHANNELS_C = (CHAN_W + 1)'(CHANNELS);

   // configuration
   sample_type direct_ff, present_ff, absent_ff;
   logic [1:0] csr_index;
   logic       csr_wr;

   // per-channel state
   sum_type   sum_ff   [CHANNELS];
   count_type count_ff [CHANNELS];
   class_type class_ff [CHANNELS];

   // stage registers
   logic          s1_v_ff;
   chan_type      s1_chan_ff;
   sample_type    s1_sample_ff;
   logic          s2_v_ff;
   chan_type      s2_chan_ff;
   sum_type       s2_sum_ff;
   logic          s3_v_ff;
   chan_type      s3_chan_ff;
   sample_type    s3_avg_ff;
   logic          rsp_valid_ff;
   chan_type      rsp_chan_ff;
   sample_type    rsp_avg_ff;
   class_type     rsp_class_ff;
   class_type     rsp_prior_ff;

   // next values and flow control
   logic             req_go;
   logic             s1_go, s1_free, s1_done;
   logic             s2_go, s2_free;
   logic             s3_go, s3_free;
   logic             out_free;
   logic [IDX_W-1:0] s1_idx, s3_idx;
   sum_type          s1_sum_in;
   logic [CNT_CMP_W-1:0] s1_count_in;
   logic [PROD_W-1:0]    s2_prod;
   sample_type       s3_avg_in;
   class_type        prior_in, class_in;

   // csr port
   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[3:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      case (csr_index)
         REG_DIRECT:  csr_prdata = CSR_DATA_W'(direct_ff);
         REG_PRESENT: csr_prdata = CSR_DATA_W'(present_ff);
         REG_ABSENT:  csr_prdata = CSR_DATA_W'(absent_ff);
         default:     csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         direct_ff  <= DIRECT_RESET;
         present_ff <= PRESENT_RESET;
         absent_ff  <= ABSENT_RESET;
      end else if (csr_wr) begin
         case (csr_index)
            REG_DIRECT:  direct_ff  <= csr_pwdata[SAMPLE_W-1:0];
            REG_PRESENT: present_ff <= csr_pwdata[SAMPLE_W-1:0];
            REG_ABSENT:  absent_ff  <= csr_pwdata[SAMPLE_W-1:0];
            default: ;
         endcase
      end
   end

   // flow control
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s3_go     = s3_v_ff && out_free;
   assign s3_free   = !s3_v_ff || out_free;
   assign s2_go     = s2_v_ff && s3_free;
   assign s2_free   = !s2_v_ff || s3_free;
   assign s1_go     = s1_v_ff && (!s1_done || s2_free);
   assign s1_free   = !s1_v_ff || s1_go;
   assign req_ready = s1_free;
   assign req_go    = req_valid && req_ready;

   // stage one: per-channel accumulate
   assign s1_idx      = s1_chan_ff[IDX_W-1:0];
   assign s1_sum_in   = sum_ff[s1_idx] + SUM_W'(s1_sample_ff);
   assign s1_count_in = CNT_CMP_W'(count_ff[s1_idx]) + CNT_CMP_W'(1);
   assign s1_done     = (s1_count_in == READINGS_C);

   // stage two: divide by reciprocal multiply
   assign s2_prod   = PROD_W'(s2_sum_ff) * PROD_W'(RECIP);
   assign s3_avg_in = s2_prod[RECIP_SH +: SAMPLE_W];

   // stage three: classify
   assign s3_idx   = s3_chan_ff[IDX_W-1:0];
   assign prior_in = class_ff[s3_idx];

   always_comb begin
      if (s3_avg_ff > direct_ff) begin
         class_in = CLASS_DIRECT;
      end else if (s3_avg_ff < present_ff) begin
         class_in = CLASS_APPROACHING;
      end else if ((s3_avg_ff < absent_ff) && (prior_in != CLASS_NONE)) begin
         class_in = CLASS_LEAVING;
      end else begin
         class_in = CLASS_NONE;
      end
   end

   // control and state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff      <= 1'b0;
         s2_v_ff      <= 1'b0;
         s3_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < CHANNELS; i++) begin
            sum_ff[i]   <= '0;
            count_ff[i] <= '0;
            class_ff[i] <= CLASS_NONE;
         end
      end else begin
         if (s1_free) begin
            s1_v_ff <= req_go && ({1'b0, req_channel} < CHANNELS_C);
         end
         if (s1_go) begin
            if (s1_done) begin
               sum_ff[s1_idx]   <= '0;
               count_ff[s1_idx] <= '0;
            end else begin
               sum_ff[s1_idx]   <= s1_sum_in;
               count_ff[s1_idx] <= s1_count_in[COUNT_W-1:0];
            end
         end
         if (s2_free) begin
            s2_v_ff <= s1_go && s1_done;
         end
         if (s3_free) begin
            s3_v_ff <= s2_go;
         end
         if (s3_go) begin
            class_ff[s3_idx] <= class_in;
         end
         if (out_free) begin
            rsp_valid_ff <= s3_go;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (s1_free) begin
         s1_chan_ff   <= req_channel;
         s1_sample_ff <= req_sample;
      end
      if (s1_go && s1_done && s2_free) begin
         s2_chan_ff <= s1_chan_ff;
         s2_sum_ff  <= s1_sum_in;
      end
      if (s2_go) begin
         s3_chan_ff <= s2_chan_ff;
         s3_avg_ff  <= s3_avg_in;
      end
      if (s3_go) begin
         rsp_chan_ff  <= s3_chan_ff;
         rsp_avg_ff   <= s3_avg_ff;
         rsp_class_ff <= class_in;
         rsp_prior_ff <= prior_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_channel  = rsp_chan_ff;
   assign rsp_average      = rsp_avg_ff;
   assign rsp_magnet_class = rsp_class_ff;
   assign rsp_prior_class  = rsp_prior_ff;

endmodule
